// ----- hw/rtl/assert_macros.svh -----
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, gated by active-low reset.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: label");

// Next-cycle implication, gated by active-low reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: label");

`endif

// ----- hw/rtl/qft_pkg.sv -----
// Types, constants and helper functions of the quoted field tokenizer.
package qft_pkg;

    localparam int NUM_DELIMS      = 4;
    localparam int NUM_QUOTE_PAIRS = 4;
    localparam int REG_SLOTS       = 4;   // byte slots held by one 32-bit register
    localparam int APB_AW          = 4;
    localparam int APB_DW          = 32;

    localparam logic [7:0] CH_ESC = 8'h5C;
    localparam logic [7:0] CH_EOL = 8'h0A;
    localparam logic [7:0] CH_EOS = 8'h00;

    localparam logic [1:0] REG_DELIM = 2'd0;
    localparam logic [1:0] REG_OPEN  = 2'd1;
    localparam logic [1:0] REG_CLOSE = 2'd2;
    localparam logic [1:0] REG_OPTS  = 2'd3;

    localparam int OPT_EMPTY_DELIM = 0;
    localparam int OPT_EMPTY_FINAL = 1;

    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_NO_CLOSE  = 2'd1,
        STAT_NO_OPEN   = 2'd2,
        STAT_BAD_ESC   = 2'd3
    } t_status;

    typedef enum logic [5:0] {
        MODE_DELIM      = 6'b000001,
        MODE_NORMAL     = 6'b000010,
        MODE_BLOCK      = 6'b000100,
        MODE_FROM_BLOCK = 6'b001000,
        MODE_ESCAPE     = 6'b010000,
        MODE_DISCARD    = 6'b100000
    } t_mode;

    typedef struct packed {
        logic [31:0] delim;
        logic [31:0] open_q;
        logic [31:0] close_q;
        logic [1:0]  opts;
    } t_cfg;

    typedef struct packed {
        logic       delim;
        logic       open_hit;
        logic [7:0] open_close;
        logic       close_hit;
    } t_match;

    typedef struct packed {
        logic       char_valid;
        logic [7:0] out_char;
        logic       token_end;
        logic       run_end;
        t_status    status;
    } t_result;

    // Slots past the register's four bytes read as unused.
    function automatic logic [7:0] slot_byte(input logic [31:0] r, input int i);
        logic [7:0] b;
        b = 8'h00;
        if (i < REG_SLOTS) begin
            b = r[8*i +: 8];
        end
        return b;
    endfunction

    function automatic logic [7:0] translate(input logic [7:0] c);
        logic [7:0] t;
        unique case (c)
            8'h61:   t = 8'h07;  // a -> BEL
            8'h65:   t = 8'h1B;  // e -> ESC
            8'h72:   t = 8'h0D;  // r -> CR
            8'h74:   t = 8'h09;  // t -> TAB
            8'h6E:   t = 8'h0A;  // n -> LF
            default: t = c;
        endcase
        return t;
    endfunction

endpackage

// ----- hw/rtl/qft_if.sv -----
// Stream interfaces for the character input and the token result output.
interface qft_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] ch;

    modport source (output valid, output ch, input ready);
    modport sink   (input valid, input ch, output ready);
endinterface

interface qft_out_if;
    logic       valid;
    logic       ready;
    logic       char_valid;
    logic [7:0] out_char;
    logic       token_end;
    logic       run_end;
    logic [1:0] status;

    modport source (output valid, output char_valid, output out_char, output token_end,
                    output run_end, output status, input ready);
    modport sink   (input valid, input char_valid, input out_char, input token_end,
                    input run_end, input status, output ready);
endinterface

// ----- hw/rtl/quoted_field_tokenizer.sv -----
// Top level of the quoted field tokenizer: input register, parser, result register.
// A word accepted into the input register passes the parse step into the result register
// that drives o_out, once that register is free; silent characters give no result word.
// Throughput: one character word per cycle while the result register can take it.
// A result waiting on o_out holds the parse step; intake stays open while the input
// register is empty. Reset: synchronous active-low i_rst_n clears both valid bits,
// the parse state and the configuration registers (space delimiter, no quotes).
module quoted_field_tokenizer (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    qft_in_if.sink                     i_in,
    qft_out_if.source                  o_out,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [qft_pkg::APB_AW-1:0] paddr,
    input  logic [qft_pkg::APB_DW-1:0] pwdata,
    output logic [qft_pkg::APB_DW-1:0] prdata,
    output logic                       pready
);

    qft_pkg::t_cfg    cfg;
    qft_pkg::t_match  match;
    qft_pkg::t_result step_res;
    logic             step_has;

    // input register: one accepted character waiting for the parse step
    logic             r_in_valid;
    logic [7:0]       r_in_ch;

    // result register: one finished word waiting for the sink
    logic             r_out_valid;
    qft_pkg::t_result r_out;

    logic             advance;

    qft_apb_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // compares run on the registered character
    qft_match u_match (
        .i_ch    (r_in_ch),
        .i_cfg   (cfg),
        .o_match (match)
    );

    // Parse step fires when a character is held and the result slot is free
    // or being emptied this cycle. Silent characters (quotes, backslash,
    // skipped delimiters, discarded input) step without loading a result.
    assign advance = r_in_valid && (!r_out_valid || o_out.ready);

    qft_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (advance),
        .i_ch         (r_in_ch),
        .i_opts       (cfg.opts),
        .i_match      (match),
        .o_has_result (step_has),
        .o_result     (step_res)
    );

    // intake stays open whenever the held character moves on this cycle
    assign i_in.ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.valid && i_in.ready) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in_ch <= i_in.ch;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= step_has;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && step_has) begin
            r_out <= step_res;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.char_valid = r_out.char_valid;
    assign o_out.out_char   = r_out.out_char;
    assign o_out.token_end  = r_out.token_end;
    assign o_out.run_end    = r_out.run_end;
    assign o_out.status     = r_out.status;

endmodule

// ----- hw/rtl/qft_apb_regs.sv -----
// APB configuration registers: delimiters, quote pairs and options.
module qft_apb_regs (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [qft_pkg::APB_AW-1:0] paddr,
    input  logic [qft_pkg::APB_DW-1:0] pwdata,
    output logic [qft_pkg::APB_DW-1:0] prdata,
    output logic                       pready,
    output qft_pkg::t_cfg              o_cfg
);

    qft_pkg::t_cfg r_cfg;
    logic          wr_en;
    logic [1:0]    reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[3:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.delim   <= 32'd32;
            r_cfg.open_q  <= '0;
            r_cfg.close_q <= '0;
            r_cfg.opts    <= '0;
        end else if (wr_en) begin
            unique case (reg_idx)
                qft_pkg::REG_DELIM: r_cfg.delim   <= pwdata;
                qft_pkg::REG_OPEN:  r_cfg.open_q  <= pwdata;
                qft_pkg::REG_CLOSE: r_cfg.close_q <= pwdata;
                qft_pkg::REG_OPTS:  r_cfg.opts    <= pwdata[1:0];
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            qft_pkg::REG_DELIM: prdata = r_cfg.delim;
            qft_pkg::REG_OPEN:  prdata = r_cfg.open_q;
            qft_pkg::REG_CLOSE: prdata = r_cfg.close_q;
            qft_pkg::REG_OPTS:  prdata = {30'd0, r_cfg.opts};
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

// ----- hw/rtl/qft_match.sv -----
// Parallel compare of one character against the delimiter and quote slots.
module qft_match (
    input  logic [7:0]     i_ch,
    input  qft_pkg::t_cfg  i_cfg,
    output qft_pkg::t_match o_match
);

    logic [7:0] b;
    logic       nz;

    always_comb begin
        o_match = '0;
        nz = (i_ch != qft_pkg::CH_EOS);
        for (int i = 0; i < qft_pkg::NUM_DELIMS; i++) begin
            b = qft_pkg::slot_byte(i_cfg.delim, i);
            if (nz && b != 8'h00 && b == i_ch) o_match.delim = 1'b1;
        end
        // descending walk so the lowest matching slot wins
        for (int i = qft_pkg::NUM_QUOTE_PAIRS - 1; i >= 0; i--) begin
            b = qft_pkg::slot_byte(i_cfg.open_q, i);
            if (nz && b != 8'h00 && b == i_ch) begin
                o_match.open_hit   = 1'b1;
                o_match.open_close = qft_pkg::slot_byte(i_cfg.close_q, i);
            end
        end
        for (int i = 0; i < qft_pkg::NUM_QUOTE_PAIRS; i++) begin
            b = qft_pkg::slot_byte(i_cfg.close_q, i);
            if (nz && b != 8'h00 && b == i_ch) o_match.close_hit = 1'b1;
        end
    end

endmodule

// ----- hw/rtl/qft_core.sv -----
// Parse state machine: one character in, at most one result out per step.
module qft_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_step,
    input  logic [7:0]       i_ch,
    input  logic [1:0]       i_opts,
    input  qft_pkg::t_match  i_match,
    output logic             o_has_result,
    output qft_pkg::t_result o_result
);

    qft_pkg::t_mode r_mode,     n_mode;
    logic           r_esc_ret,  n_esc_ret;
    logic [7:0]     r_exp_close, n_exp_close;
    logic           r_nonempty, n_nonempty;

    logic       do_normal;
    logic       do_finish;
    logic       do_append;
    logic [7:0] app_ch;

    always_comb begin
        n_mode       = r_mode;
        n_esc_ret    = r_esc_ret;
        n_exp_close  = r_exp_close;
        n_nonempty   = r_nonempty;
        o_has_result = 1'b0;
        o_result     = '0;
        do_normal    = 1'b0;
        do_finish    = 1'b0;
        do_append    = 1'b0;
        app_ch       = i_ch;

        unique case (r_mode)
            qft_pkg::MODE_DELIM: begin
                if (i_match.delim) begin
                    if (i_opts[qft_pkg::OPT_EMPTY_DELIM]) begin
                        o_has_result       = 1'b1;
                        o_result.token_end = 1'b1;
                    end
                end else begin
                    do_normal = 1'b1;
                end
            end
            qft_pkg::MODE_NORMAL: begin
                do_normal = 1'b1;
            end
            qft_pkg::MODE_BLOCK: begin
                if (i_ch == qft_pkg::CH_ESC) begin
                    n_esc_ret = 1'b1;
                    n_mode    = qft_pkg::MODE_ESCAPE;
                end else if (i_ch == qft_pkg::CH_EOS) begin
                    do_finish        = 1'b1;
                    o_has_result     = 1'b1;
                    o_result.run_end = 1'b1;
                    o_result.status  = qft_pkg::STAT_NO_CLOSE;
                end else if (r_exp_close != 8'h00 && i_ch == r_exp_close) begin
                    n_mode = qft_pkg::MODE_FROM_BLOCK;
                end else begin
                    do_append = 1'b1;
                end
            end
            qft_pkg::MODE_FROM_BLOCK: begin
                // an adjacent opening quote merges into the same token
                if (i_match.open_hit) begin
                    n_exp_close = i_match.open_close;
                    n_mode      = qft_pkg::MODE_BLOCK;
                end else begin
                    do_normal = 1'b1;
                end
            end
            qft_pkg::MODE_ESCAPE: begin
                if (i_ch == qft_pkg::CH_EOS) begin
                    do_finish        = 1'b1;
                    o_has_result     = 1'b1;
                    o_result.run_end = 1'b1;
                    o_result.status  = qft_pkg::STAT_BAD_ESC;
                end else begin
                    n_mode    = r_esc_ret ? qft_pkg::MODE_BLOCK : qft_pkg::MODE_NORMAL;
                    do_append = 1'b1;
                    app_ch    = qft_pkg::translate(i_ch);
                end
            end
            qft_pkg::MODE_DISCARD: begin
                if (i_ch == qft_pkg::CH_EOS) do_finish = 1'b1;
            end
            default: begin
                n_mode = qft_pkg::MODE_DELIM;
            end
        endcase

        if (do_normal) begin
            n_mode = qft_pkg::MODE_NORMAL;
            priority if (i_ch == qft_pkg::CH_ESC) begin
                n_esc_ret = 1'b0;
                n_mode    = qft_pkg::MODE_ESCAPE;
            end else if (i_ch == qft_pkg::CH_EOS || i_ch == qft_pkg::CH_EOL) begin
                do_finish          = 1'b1;
                o_has_result       = 1'b1;
                o_result.token_end = r_nonempty || i_opts[qft_pkg::OPT_EMPTY_FINAL];
                o_result.run_end   = 1'b1;
            end else if (i_match.delim) begin
                n_nonempty         = 1'b0;
                n_mode             = qft_pkg::MODE_DELIM;
                o_has_result       = 1'b1;
                o_result.token_end = 1'b1;
            end else if (i_match.open_hit) begin
                n_exp_close = i_match.open_close;
                n_nonempty  = 1'b1;
                n_mode      = qft_pkg::MODE_BLOCK;
            end else if (i_match.close_hit) begin
                do_finish        = 1'b1;
                o_has_result     = 1'b1;
                o_result.run_end = 1'b1;
                o_result.status  = qft_pkg::STAT_NO_OPEN;
            end else begin
                do_append = 1'b1;
            end
        end

        if (do_append) begin
            n_nonempty          = 1'b1;
            o_has_result        = 1'b1;
            o_result.char_valid = 1'b1;
            o_result.out_char   = app_ch;
        end

        if (do_finish) begin
            n_mode      = (i_ch == qft_pkg::CH_EOS) ? qft_pkg::MODE_DELIM
                                                    : qft_pkg::MODE_DISCARD;
            n_esc_ret   = 1'b0;
            n_exp_close = 8'h00;
            n_nonempty  = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= qft_pkg::MODE_DELIM;
            r_esc_ret   <= 1'b0;
            r_exp_close <= 8'h00;
            r_nonempty  <= 1'b0;
        end else if (i_step) begin
            r_mode      <= n_mode;
            r_esc_ret   <= n_esc_ret;
            r_exp_close <= n_exp_close;
            r_nonempty  <= n_nonempty;
        end
    end

endmodule

// ----- hw/rtl/qft_checker.sv -----
// Port-level checks on result words of the tokenizer, bound to the top level.
`include "assert_macros.svh"

module qft_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_out_valid,
    input logic       i_char_valid,
    input logic [7:0] i_out_char,
    input logic       i_token_end,
    input logic       i_run_end,
    input logic [1:0] i_status
);

    logic ok_status;
    logic char_word;
    logic err_end;

    assign ok_status = (i_status == qft_pkg::STAT_OK);
    assign char_word = i_out_valid && i_char_valid;
    assign err_end   = i_out_valid && i_run_end && !ok_status;

    // a character word never also closes a token or a run
    `ASSERT_IMPLIES(a_char_alone, i_clk, i_rst_n, char_word, !i_token_end && !i_run_end)

    // status is only reported on a run end
    `ASSERT_IMPLIES(a_status_on_run_end, i_clk, i_rst_n, i_out_valid && !i_run_end, ok_status)

    // no character payload without its flag
    `ASSERT_IMPLIES(a_char_zero, i_clk, i_rst_n, i_out_valid && !i_char_valid, i_out_char == 8'h00)

    // an error ending never completes a token
    `ASSERT_IMPLIES(a_error_no_token, i_clk, i_rst_n, err_end, !i_token_end)

endmodule

bind quoted_field_tokenizer qft_checker u_qft_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_out_valid  (o_out.valid),
    .i_char_valid (o_out.char_valid),
    .i_out_char   (o_out.out_char),
    .i_token_end  (o_out.token_end),
    .i_run_end    (o_out.run_end),
    .i_status     (o_out.status)
);

// ----- tb/sv/quoted_field_tokenizer_tb.sv -----
// Self-checking testbench of the quoted field tokenizer: random strings against a local parser.
`timescale 1ns / 100ps

module quoted_field_tokenizer_tb;
    import qft_pkg::*;

    // Generous cycle ceiling; a correct run needs a small fraction of it.
    localparam int RUN_LIMIT = 200000;

    logic              i_clk;
    logic              i_rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    qft_in_if  in_if ();
    qft_out_if out_if ();

    quoted_field_tokenizer dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // ------------------------------------------------------------------
    // Parser shadow: configuration copy plus the four pieces of parse state
    // ------------------------------------------------------------------
    logic [31:0] cfg_delim;
    logic [31:0] cfg_open;
    logic [31:0] cfg_close;
    logic [1:0]  cfg_opts;

    t_mode       pmode;
    logic        esc_to_block;   // escape returns into a quoted block
    logic [7:0]  close_wanted;   // closing byte of the open block, 0 = never closes
    logic        tok_started;    // current token counts as non-empty

    logic [7:0]  char_feed [$];  // characters waiting for the driver
    t_result     due_words [$];  // predicted result words, oldest first
    int          issued;         // result words predicted (driver only)
    int          words_checked;  // result words matched (monitor, nonblocking)
    int          mismatches;
    int          run_cycles;
    bit          tx_steady;      // phase with no sender gaps

    // Directed opening string under the first config (space, LF, comma delimiters;
    // quote pairs "" '' () and an unpaired '[' opener; both options on).
    logic [7:0] opening [25] = '{
        8'h20, 8'h0A,                           // leading space and LF, both delimiters -> empty tokens
        8'h22, 8'h61, 8'h20, 8'h22,             // "a " -> a, space kept inside block
        8'h27, 8'h63, 8'h27,                    // adjacent 'c' merges into same token
        8'h2C, 8'h2C,                           // extra delimiter -> empty token
        8'h5C, 8'h6E, 8'hFF, 8'h5C, 8'h5C,      // \n -> LF, 0xFF, \\ -> backslash
        8'h0A, 8'h00,                           // LF ends run in normal mode, zero ends discard
        8'h29, 8'h00,                           // stray close quote
        8'h5B, 8'h71, 8'h00,                    // opener with no closer -> missing close
        8'h5C, 8'h00                            // dangling escape
    };

    function automatic t_result word_of(input logic cv, input logic [7:0] c, input logic te,
                                        input logic re, input t_status st);
        t_result w;
        w.char_valid = cv;
        w.out_char   = c;
        w.token_end  = te;
        w.run_end    = re;
        w.status     = st;
        return w;
    endfunction

    // Byte hit in any used slot of a packed register; zero never matches.
    function automatic bit hits(input logic [31:0] r, input logic [7:0] c);
        bit h;
        h = 1'b0;
        if (c != CH_EOS) begin
            for (int i = 0; i < 4; i++) begin
                if (r[8*i +: 8] != 8'h00 && r[8*i +: 8] == c) h = 1'b1;
            end
        end
        return h;
    endfunction

    // Opening quote lookup; walking down makes the lowest matching slot win.
    function automatic bit open_lookup(input logic [7:0] c, output logic [7:0] cl);
        bit h;
        h  = 1'b0;
        cl = 8'h00;
        if (c != CH_EOS) begin
            for (int i = 3; i >= 0; i--) begin
                if (cfg_open[8*i +: 8] != 8'h00 && cfg_open[8*i +: 8] == c) begin
                    h  = 1'b1;
                    cl = cfg_close[8*i +: 8];
                end
            end
        end
        return h;
    endfunction

    function automatic logic [7:0] unescape(input logic [7:0] c);
        case (c)
            8'h61:   return 8'h07;
            8'h65:   return 8'h1B;
            8'h72:   return 8'h0D;
            8'h74:   return 8'h09;
            8'h6E:   return 8'h0A;
            default: return c;
        endcase
    endfunction

    // Zero restarts cleanly; any other terminator drops input up to the next zero.
    function automatic void end_run(input logic [7:0] c);
        pmode        = (c == CH_EOS) ? MODE_DELIM : MODE_DISCARD;
        esc_to_block = 1'b0;
        close_wanted = 8'h00;
        tok_started  = 1'b0;
    endfunction

    function automatic bit plain_char(input logic [7:0] c, output t_result w);
        logic       te;
        logic [7:0] cl;
        w     = '0;
        pmode = MODE_NORMAL;
        if (c == CH_ESC) begin
            esc_to_block = 1'b0;
            pmode        = MODE_ESCAPE;
            return 1'b0;
        end
        if (c == CH_EOS || c == CH_EOL) begin
            te = tok_started || cfg_opts[OPT_EMPTY_FINAL];
            end_run(c);
            w = word_of(1'b0, 8'h00, te, 1'b1, STAT_OK);
            return 1'b1;
        end
        if (hits(cfg_delim, c)) begin
            tok_started = 1'b0;
            pmode       = MODE_DELIM;
            w = word_of(1'b0, 8'h00, 1'b1, 1'b0, STAT_OK);
            return 1'b1;
        end
        if (open_lookup(c, cl)) begin
            // an opener alone already makes the token non-empty
            close_wanted = cl;
            tok_started  = 1'b1;
            pmode        = MODE_BLOCK;
            return 1'b0;
        end
        if (hits(cfg_close, c)) begin
            end_run(c);
            w = word_of(1'b0, 8'h00, 1'b0, 1'b1, STAT_NO_OPEN);
            return 1'b1;
        end
        tok_started = 1'b1;
        w = word_of(1'b1, c, 1'b0, 1'b0, STAT_OK);
        return 1'b1;
    endfunction

    // One accepted character; returns 1 when it produces a result word.
    function automatic bit tokenize_char(input logic [7:0] c, output t_result w);
        logic [7:0] cl;
        w = '0;
        case (pmode)
            MODE_NORMAL: return plain_char(c, w);
            MODE_BLOCK: begin
                if (c == CH_ESC) begin
                    esc_to_block = 1'b1;
                    pmode        = MODE_ESCAPE;
                    return 1'b0;
                end
                if (c == CH_EOS) begin
                    end_run(c);
                    w = word_of(1'b0, 8'h00, 1'b0, 1'b1, STAT_NO_CLOSE);
                    return 1'b1;
                end
                if (close_wanted != 8'h00 && c == close_wanted) begin
                    pmode = MODE_FROM_BLOCK;
                    return 1'b0;
                end
                tok_started = 1'b1;
                w = word_of(1'b1, c, 1'b0, 1'b0, STAT_OK);
                return 1'b1;
            end
            MODE_FROM_BLOCK: begin
                // another opener right after a closer continues the same token
                if (open_lookup(c, cl)) begin
                    close_wanted = cl;
                    pmode        = MODE_BLOCK;
                    return 1'b0;
                end
                return plain_char(c, w);
            end
            MODE_ESCAPE: begin
                if (c == CH_EOS) begin
                    end_run(c);
                    w = word_of(1'b0, 8'h00, 1'b0, 1'b1, STAT_BAD_ESC);
                    return 1'b1;
                end
                pmode       = esc_to_block ? MODE_BLOCK : MODE_NORMAL;
                tok_started = 1'b1;
                w = word_of(1'b1, unescape(c), 1'b0, 1'b0, STAT_OK);
                return 1'b1;
            end
            MODE_DISCARD: begin
                if (c == CH_EOS) end_run(c);
                return 1'b0;
            end
            default: begin
                // delimiter run: skipped, or empty tokens under the option; LF that is a delimiter counts here too
                if (hits(cfg_delim, c)) begin
                    pmode = MODE_DELIM;
                    if (cfg_opts[OPT_EMPTY_DELIM]) begin
                        w = word_of(1'b0, 8'h00, 1'b1, 1'b0, STAT_OK);
                        return 1'b1;
                    end
                    return 1'b0;
                end
                return plain_char(c, w);
            end
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic logic [7:0] any_slot(input logic [31:0] r);
        logic [7:0] b;
        int         k;
        b = 8'h00;
        repeat (8) begin
            if (b == 8'h00) begin
                k = $urandom_range(0, 3);
                b = r[8*k +: 8];
            end
        end
        return b;
    endfunction

    function automatic logic [7:0] palette_byte();
        case ($urandom_range(0, 15))
            0:       return 8'h20;  // space
            1:       return 8'h2C;  // comma
            2:       return 8'h3B;  // semicolon
            3:       return 8'h09;  // tab
            4:       return CH_EOL;
            5:       return 8'h22;  // double quote
            6:       return 8'h27;  // single quote
            7:       return 8'h28;
            8:       return 8'h29;
            9:       return 8'h5B;
            10:      return 8'h5D;
            11:      return 8'h7B;
            12:      return 8'h7D;
            13:      return CH_ESC;
            14:      return 8'h7C;
            default: return 8'($urandom_range(1, 255));
        endcase
    endfunction

    function automatic logic [31:0] rand_slots();
        logic [31:0] r;
        for (int k = 0; k < 4; k++) begin
            r[8*k +: 8] = ($urandom_range(0, 3) == 0) ? 8'h00 : palette_byte();
        end
        return r;
    endfunction

    function automatic logic [7:0] plain_byte();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 70) return 8'h61 + 8'($urandom_range(0, 25));
        if (pick < 85) return 8'h30 + 8'($urandom_range(0, 9));
        return 8'($urandom_range(1, 255));
    endfunction

    function automatic logic [7:0] escape_byte();
        case ($urandom_range(0, 7))
            0:       return 8'h61;
            1:       return 8'h65;
            2:       return 8'h72;
            3:       return 8'h74;
            4:       return 8'h6E;
            5:       return CH_ESC;
            6:       return 8'h71;
            default: return 8'($urandom_range(1, 255));
        endcase
    endfunction

    // Any nonzero byte, weighted toward the configured special bytes.
    function automatic logic [7:0] loose_char();
        int         pick;
        logic [7:0] c;
        pick = $urandom_range(0, 99);
        if (pick < 40)      c = plain_byte();
        else if (pick < 55) c = any_slot(cfg_delim);
        else if (pick < 63) c = any_slot(cfg_open);
        else if (pick < 71) c = any_slot(cfg_close);
        else if (pick < 78) c = CH_ESC;
        else if (pick < 81) c = CH_EOL;
        else                c = 8'($urandom_range(1, 255));
        if (c == CH_EOS) c = 8'h78;
        return c;
    endfunction

    function automatic void push_delim();
        logic [7:0] b;
        b = any_slot(cfg_delim);
        if (b != 8'h00) char_feed.push_back(b);
    endfunction

    // One string: mostly well-formed tokens with random content, else noise.
    function automatic void queue_line(input bit tidy);
        int  slot;
        bit  first;
        if (!tidy) begin
            repeat ($urandom_range(1, 16)) char_feed.push_back(loose_char());
            if ($urandom_range(0, 3) != 0) char_feed.push_back(CH_EOS);
            return;
        end
        first = 1'b1;
        repeat ($urandom_range(0, 2)) push_delim();
        repeat ($urandom_range(1, 4)) begin
            if (!first) repeat ($urandom_range(1, 2)) push_delim();
            first = 1'b0;
            repeat ($urandom_range(1, 3)) begin
                case ($urandom_range(0, 4))
                    0, 1: repeat ($urandom_range(1, 4)) char_feed.push_back(plain_byte());
                    2: begin
                        char_feed.push_back(CH_ESC);
                        char_feed.push_back(escape_byte());
                    end
                    default: begin
                        slot = $urandom_range(0, 3);
                        if (cfg_open[8*slot +: 8] != 8'h00) begin
                            char_feed.push_back(cfg_open[8*slot +: 8]);
                            repeat ($urandom_range(0, 4)) begin
                                if ($urandom_range(0, 4) == 0) begin
                                    char_feed.push_back(CH_ESC);
                                    char_feed.push_back(escape_byte());
                                end else if ($urandom_range(0, 3) == 0) begin
                                    push_delim();
                                end else begin
                                    char_feed.push_back(plain_byte());
                                end
                            end
                            // now and then leave the block open
                            if (cfg_close[8*slot +: 8] != 8'h00 && $urandom_range(0, 9) != 0)
                                char_feed.push_back(cfg_close[8*slot +: 8]);
                        end
                    end
                endcase
            end
        end
        if ($urandom_range(0, 2) == 0) push_delim();
        case ($urandom_range(0, 9))
            0: begin
                // LF terminator, then junk that must be dropped up to the zero
                char_feed.push_back(CH_EOL);
                char_feed.push_back(loose_char());
                char_feed.push_back(CH_EOS);
            end
            1: begin
                char_feed.push_back(CH_ESC);
                char_feed.push_back(CH_EOS);
            end
            default: char_feed.push_back(CH_EOS);
        endcase
    endfunction

    function automatic void fill_random(input int n);
        int goal;
        goal = char_feed.size() + n;
        while (char_feed.size() < goal) queue_line($urandom_range(0, 3) != 0);
    endfunction

    // Block idle: every word sent, every result back.
    task automatic settle();
        do @(negedge i_clk);
        while (char_feed.size() != 0 || in_if.valid || issued != words_checked);
        repeat (4) @(negedge i_clk);
    endtask

    // Setup cycle, then access cycle; the register takes the value at the access edge.
    task automatic apb_write(input logic [1:0] idx, input logic [31:0] val);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        case (idx)
            REG_DELIM: cfg_delim = val;
            REG_OPEN:  cfg_open  = val;
            REG_CLOSE: cfg_close = val;
            REG_OPTS:  cfg_opts  = val[1:0];
            default:   ;
        endcase
    endtask

    task automatic apply_cfg(input logic [31:0] d, input logic [31:0] o, input logic [31:0] c,
                             input logic [1:0] opts);
        settle();
        apb_write(REG_DELIM, d);
        apb_write(REG_OPEN, o);
        apb_write(REG_CLOSE, c);
        apb_write(REG_OPTS, {30'd0, opts});
        @(negedge i_clk);
        tx_steady = ($urandom_range(0, 3) == 0);
    endtask

    // ------------------------------------------------------------------
    // Clock
    // ------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Sequencer: reset, then config phases each followed by a batch of strings
    // ------------------------------------------------------------------
    initial begin
        i_rst_n       = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        in_if.valid   = 1'b0;
        in_if.ch      = 8'h00;
        out_if.ready  = 1'b0;
        tx_steady     = 1'b0;
        issued        = 0;
        words_checked = 0;
        mismatches    = 0;
        // register and parser reset values
        cfg_delim     = 32'h0000_0020;
        cfg_open      = 32'h0;
        cfg_close     = 32'h0;
        cfg_opts      = 2'b00;
        pmode         = MODE_DELIM;
        esc_to_block  = 1'b0;
        close_wanted  = 8'h00;
        tok_started   = 1'b0;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset defaults: space delimiter only, no quotes
        @(negedge i_clk);
        fill_random(100);

        // directed string plus random under the mixed config
        apply_cfg(32'h002C_0A20, 32'h5B28_2722, 32'h0029_2722, 2'b11);
        foreach (opening[i]) char_feed.push_back(opening[i]);
        fill_random(200);

        // low extreme: nothing configured
        apply_cfg(32'h0, 32'h0, 32'h0, 2'b00);
        fill_random(150);

        // high extreme: 0xFF in every slot, opener equals closer
        apply_cfg(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 2'b11);
        fill_random(150);

        // random slot contents, duplicates and overlaps included
        repeat (6) begin
            apply_cfg(rand_slots(), rand_slots(), rand_slots(), 2'($urandom_range(0, 3)));
            fill_random(210);
        end

        settle();
        if (due_words.size() != 0) begin
            $error("%0d result words never arrived", due_words.size());
            mismatches++;
        end
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // ------------------------------------------------------------------
    // Driver: bursts of random length, random gaps, occasional full drain
    // ------------------------------------------------------------------
    int burst_left = 1;
    int gap_left   = 0;
    bit drain_hold = 1'b0;
    bit drained    = 1'b0;

    always @(posedge i_clk) begin : feed_chars
        t_result w;
        bit      hit;
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
            in_if.ch    <= 8'h00;
        end else begin
            // predict at the accepting edge, with the config in force now
            if (in_if.valid && in_if.ready) begin
                hit = tokenize_char(in_if.ch, w);
                if (hit) begin
                    due_words.push_back(w);
                    issued++;
                end
            end
            if (in_if.valid && !in_if.ready) begin
                // word still waiting; hold it
            end else if (drain_hold) begin
                in_if.valid <= 1'b0;
                if (issued == words_checked) drain_hold = 1'b0;
            end else if (gap_left != 0) begin
                in_if.valid <= 1'b0;
                gap_left--;
            end else if (char_feed.size() != 0) begin
                in_if.valid <= 1'b1;
                in_if.ch    <= char_feed.pop_front();
                if (burst_left <= 1) begin
                    burst_left = $urandom_range(1, 24);
                    gap_left   = tx_steady ? 0 : $urandom_range(0, 6);
                    // first burst always, then now and then: wait for all results
                    if (!drained || $urandom_range(0, 15) == 0) begin
                        drain_hold = 1'b1;
                        drained    = 1'b1;
                    end
                end else begin
                    burst_left--;
                end
            end else begin
                in_if.valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: ready follows a stall pattern that is redrawn at random; compare each word
    // ------------------------------------------------------------------
    int rx_tick    = 0;
    int stall_mode = 0;

    function automatic void check_field(input string name, input logic [7:0] want,
                                        input logic [7:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge i_clk) begin : watch_results
        t_result want;
        logic    rdy;
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
        end else begin
            rx_tick++;
            if (rx_tick % 200 == 0) stall_mode = $urandom_range(0, 3);
            case (stall_mode)
                0:       rdy = 1'b1;
                1:       rdy = $urandom_range(0, 1);
                2:       rdy = (rx_tick % 4 == 0);
                default: rdy = ($urandom_range(0, 7) != 0);
            endcase
            out_if.ready <= rdy;

            if (out_if.valid && out_if.ready) begin
                if (due_words.size() == 0) begin
                    $error("result word with nothing expected");
                    mismatches++;
                end else begin
                    want = due_words.pop_front();
                    check_field("char_valid", 8'(want.char_valid), 8'(out_if.char_valid));
                    check_field("out_char", want.out_char, out_if.out_char);
                    check_field("token_end", 8'(want.token_end), 8'(out_if.token_end));
                    check_field("run_end", 8'(want.run_end), 8'(out_if.run_end));
                    check_field("status", 8'(want.status), 8'(out_if.status));
                    words_checked <= words_checked + 1;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog
    // ------------------------------------------------------------------
    initial run_cycles = 0;

    always @(posedge i_clk) begin
        run_cycles <= run_cycles + 1;
        if (run_cycles == RUN_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

endmodule
